// ----- rtl/pid_controller_ramp_limited_assert.svh -----
// Assertion macros shared by the PID controller RTL.
// No dependencies; clocked on clk with asynchronous active-low rst_n.
`ifndef PID_CONTROLLER_RAMP_LIMITED_ASSERT_SVH
`define PID_CONTROLLER_RAMP_LIMITED_ASSERT_SVH

// Same-cycle implication.
`define PCRL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pcrl_pkg.sv -----
// Shared types, constants and arithmetic helpers for the PID controller.
// No dependencies.
package pcrl_pkg;

    localparam int DATA_W = 32;
    localparam int DT_W   = 19;
    localparam int M_W    = 20;
    localparam int DIV_N_W = 68;
    localparam int DIV_D_W = 21;
    localparam int DIV_Q_W = 34;
    localparam int ACC_W  = 84;
    localparam int CFG_IDX_W = 3;

    localparam logic [DT_W-1:0]    DT_DEFAULT_US = 19'd1000;
    localparam logic [31:0]        DT_MAX_US     = 32'd500000;
    localparam logic [M_W-1:0]     US_PER_S      = 20'd1000000;

    // floor(N / 15625) for N below 15625 * 2^32: estimate with a reciprocal, then fix by up to 3
    localparam logic [32:0] RECIP_M   = 33'd4503599627;
    localparam logic [32:0] C_DIVISOR = 33'd15625;
    localparam logic [15:0] C_STEP1   = 16'd15625;
    localparam logic [15:0] C_STEP2   = 16'd31250;
    localparam logic [15:0] C_STEP3   = 16'd46875;
    localparam logic [60:0] C_OVF_LIM = 61'd67108864000000;

    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DT,
        OP_PMUL,
        OP_PSAT,
        OP_IMUL,
        OP_DMUL,
        OP_WLO,
        OP_WHI,
        OP_DIV,
        OP_CMUL,
        OP_CBACK,
        OP_CFIX,
        OP_IFIN,
        OP_DFIN,
        OP_RMUL,
        OP_RFIN,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic ramp_off;
        logic out_free;
    } status_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

    function automatic logic signed [31:0] sat_mag(input logic [DIV_Q_W-1:0] q,
                                                   input logic ovf, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (ovf || q > 34'h080000000) r = 32'sh80000000;
            else r = -$signed(q[31:0]);
        end
        else begin
            if (ovf || q > 34'h07fffffff) r = 32'sh7fffffff;
            else r = $signed(q[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_lim(input logic signed [33:0] v,
                                                     input logic [30:0] lim);
        logic signed [33:0] l;
        logic signed [31:0] r;
        l = $signed({3'b000, lim});
        if (v > l) r = l[31:0];
        else if (v < -l) r = 32'(-l);
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh07fffffff) r = 32'sh7fffffff;
        else if (v < -34'sh080000000) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// ----- rtl/pcrl_div.sv -----
// Sequential restoring divider, one quotient bit per cycle, overflow flagged.
// Depends on pcrl_pkg.
module pcrl_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pcrl_pkg::DIV_N_W-1:0]     dividend,
    input  logic [pcrl_pkg::DIV_D_W-1:0]     divisor,
    output logic                             busy,
    output logic                             ovf,
    output logic [pcrl_pkg::DIV_Q_W-1:0]     quotient
);
    logic                           busy_reg, busy_next;
    logic                           ovf_reg, ovf_next;
    logic [5:0]                     cnt_reg, cnt_next;
    logic [pcrl_pkg::DIV_D_W-1:0]   rem_reg, rem_next;
    logic [pcrl_pkg::DIV_Q_W-1:0]   sh_reg, sh_next;
    logic [pcrl_pkg::DIV_D_W-1:0]   d_reg, d_next;
    logic [pcrl_pkg::DIV_D_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        d_next    = d_reg;
        trial     = {rem_reg, sh_reg[pcrl_pkg::DIV_Q_W-1]};
        if (start) begin
            d_next = divisor;
            if (dividend[67:34] >= {13'd0, divisor}) begin
                ovf_next  = 1'b1;
                busy_next = 1'b0;
            end
            else begin
                ovf_next  = 1'b0;
                busy_next = 1'b1;
                rem_next  = dividend[54:34];
                sh_next   = dividend[33:0];
                cnt_next  = 6'(pcrl_pkg::DIV_Q_W);
            end
        end
        else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = pcrl_pkg::DIV_D_W'(trial - {1'b0, d_reg});
                sh_next  = {sh_reg[pcrl_pkg::DIV_Q_W-2:0], 1'b1};
            end
            else begin
                rem_next = trial[pcrl_pkg::DIV_D_W-1:0];
                sh_next  = {sh_reg[pcrl_pkg::DIV_Q_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 6'd1;
            busy_next = (cnt_reg != 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        d_reg   <= d_next;
    end

    assign busy     = busy_reg;
    assign ovf      = ovf_reg;
    assign quotient = sh_reg;

endmodule

// ----- rtl/pcrl_dp.sv -----
// Datapath: configuration, loop state, shared multiplier, divider and output register.
// Depends on pcrl_pkg, pcrl_div and the assertion macro header.
`include "pid_controller_ramp_limited_assert.svh"

module pcrl_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pcrl_pkg::cmd_t                    cmd,
    output pcrl_pkg::status_t                 status,
    input  logic [63:0]                       in_data,
    input  logic                              cfg_we,
    input  logic [pcrl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       out_data
);
    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0]        ramp_reg, limit_reg;
    logic signed [31:0] last_err_reg, integ_sum_reg, last_drv_reg;
    logic [31:0]        last_time_reg;

    logic signed [31:0] e_reg, p_reg, integ_reg, drv_reg;
    logic [31:0]        now_reg;
    logic [pcrl_pkg::DT_W-1:0]    dt_reg;
    logic [pcrl_pkg::M_W-1:0]     m_reg;
    logic [pcrl_pkg::DIV_D_W-1:0] dsr_reg;
    logic               neg_reg;
    logic [63:0]        x_reg;
    logic [pcrl_pkg::ACC_W-1:0]   acc_reg;
    logic [31:0]        cqe_reg, cq_reg;
    logic [15:0]        crem_reg;
    logic               cov_reg;
    logic [31:0]        out_reg;

    logic [32:0]        mul_a, mul_b;
    logic [65:0]        prod;
    logic [31:0]        tdiff;
    logic signed [32:0] s_sum, s_dif;
    logic               div_busy, div_ovf;
    logic [pcrl_pkg::DIV_Q_W-1:0] div_q;
    logic signed [31:0] q_sat, c_sat;
    logic [1:0]         c_fix;
    logic signed [33:0] rdiff, rstep, rnew;
    logic               do_commit;

    assign s_sum = 33'(e_reg) + 33'(last_err_reg);
    assign s_dif = 33'(e_reg) - 33'(last_err_reg);
    assign tdiff = now_reg - last_time_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            pcrl_pkg::OP_PMUL:
            begin
                mul_a = pcrl_pkg::mag33(33'(kp_reg));
                mul_b = pcrl_pkg::mag33(33'(e_reg));
            end
            pcrl_pkg::OP_IMUL:
            begin
                mul_a = pcrl_pkg::mag33(33'(ki_reg));
                mul_b = pcrl_pkg::mag33(s_sum);
            end
            pcrl_pkg::OP_DMUL:
            begin
                mul_a = pcrl_pkg::mag33(33'(kd_reg));
                mul_b = pcrl_pkg::mag33(s_dif);
            end
            pcrl_pkg::OP_WLO:
            begin
                mul_a = {1'b0, x_reg[31:0]};
                mul_b = 33'(m_reg);
            end
            pcrl_pkg::OP_WHI:
            begin
                mul_a = {1'b0, x_reg[63:32]};
                mul_b = 33'(m_reg);
            end
            pcrl_pkg::OP_CMUL:
            begin
                mul_a = {1'b0, acc_reg[68:37]};
                mul_b = pcrl_pkg::RECIP_M;
            end
            pcrl_pkg::OP_CBACK:
            begin
                mul_a = {1'b0, cqe_reg};
                mul_b = pcrl_pkg::C_DIVISOR;
            end
            pcrl_pkg::OP_RMUL:
            begin
                mul_a = 33'(ramp_reg);
                mul_b = 33'(dt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    pcrl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == pcrl_pkg::OP_DIV),
        .dividend (acc_reg[pcrl_pkg::ACC_W-1:16]),
        .divisor  (dsr_reg),
        .busy     (div_busy),
        .ovf      (div_ovf),
        .quotient (div_q)
    );

    assign q_sat = pcrl_pkg::sat_mag(div_q, div_ovf, neg_reg);
    assign c_sat = pcrl_pkg::sat_mag({2'b00, cq_reg}, cov_reg, neg_reg);

    always_comb
    begin
        if (crem_reg >= pcrl_pkg::C_STEP3) c_fix = 2'd3;
        else if (crem_reg >= pcrl_pkg::C_STEP2) c_fix = 2'd2;
        else if (crem_reg >= pcrl_pkg::C_STEP1) c_fix = 2'd1;
        else c_fix = 2'd0;
    end

    assign rdiff = 34'(drv_reg) - 34'(last_drv_reg);
    assign rstep = $signed({2'b00, cq_reg});
    always_comb
    begin
        if (rdiff > rstep) rnew = 34'(last_drv_reg) + rstep;
        else if (rdiff < -rstep) rnew = 34'(last_drv_reg) - rstep;
        else rnew = 34'(drv_reg);
    end

    assign do_commit = (cmd.op == pcrl_pkg::OP_COMMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            ramp_reg      <= '0;
            limit_reg     <= '1;
            last_err_reg  <= '0;
            integ_sum_reg <= '0;
            last_drv_reg  <= '0;
            last_time_reg <= '0;
            out_valid     <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    pcrl_pkg::CFG_KP:    kp_reg    <= cfg_data;
                    pcrl_pkg::CFG_KI:    ki_reg    <= cfg_data;
                    pcrl_pkg::CFG_KD:    kd_reg    <= cfg_data;
                    pcrl_pkg::CFG_RAMP:  ramp_reg  <= cfg_data[30:0];
                    pcrl_pkg::CFG_LIMIT: limit_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (do_commit) begin
                integ_sum_reg <= integ_reg;
                last_drv_reg  <= drv_reg;
                last_err_reg  <= e_reg;
                last_time_reg <= now_reg;
                out_valid     <= 1'b1;
            end
            else if (out_ready) begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pcrl_pkg::OP_LOAD:
            begin
                e_reg   <= in_data[31:0];
                now_reg <= in_data[63:32];
            end
            pcrl_pkg::OP_DT:
            begin
                if (tdiff == 32'd0 || tdiff > pcrl_pkg::DT_MAX_US) dt_reg <= pcrl_pkg::DT_DEFAULT_US;
                else dt_reg <= tdiff[pcrl_pkg::DT_W-1:0];
            end
            pcrl_pkg::OP_PMUL:
            begin
                x_reg   <= prod[63:0];
                neg_reg <= kp_reg[31] ^ e_reg[31];
            end
            pcrl_pkg::OP_PSAT:
                p_reg  <= pcrl_pkg::sat_mag(x_reg[49:16], |x_reg[63:50], neg_reg);
            pcrl_pkg::OP_IMUL:
            begin
                x_reg   <= prod[63:0];
                neg_reg <= ki_reg[31] ^ s_sum[32];
                m_reg   <= pcrl_pkg::M_W'(dt_reg);
            end
            pcrl_pkg::OP_DMUL:
            begin
                x_reg   <= prod[63:0];
                neg_reg <= kd_reg[31] ^ s_dif[32];
                m_reg   <= pcrl_pkg::US_PER_S;
                dsr_reg <= pcrl_pkg::DIV_D_W'(dt_reg);
            end
            pcrl_pkg::OP_WLO: acc_reg <= pcrl_pkg::ACC_W'(prod);
            pcrl_pkg::OP_WHI: acc_reg <= acc_reg + {prod[51:0], 32'd0};
            pcrl_pkg::OP_CMUL:
            begin
                cqe_reg <= prod[63:32];
                cov_reg <= (acc_reg[83:23] >= pcrl_pkg::C_OVF_LIM);
            end
            pcrl_pkg::OP_CBACK: crem_reg <= acc_reg[38:23] - prod[15:0];
            pcrl_pkg::OP_CFIX: cq_reg <= cqe_reg + 32'(c_fix);
            pcrl_pkg::OP_RMUL: acc_reg <= pcrl_pkg::ACC_W'({prod[49:0], 17'd0});
            pcrl_pkg::OP_IFIN:
                integ_reg <= pcrl_pkg::clamp_lim(34'(integ_sum_reg) + 34'(c_sat), limit_reg);
            pcrl_pkg::OP_DFIN:
                drv_reg <= pcrl_pkg::clamp_lim(34'(p_reg) + 34'(integ_reg) + 34'(q_sat),
                                               limit_reg);
            pcrl_pkg::OP_RFIN: drv_reg <= pcrl_pkg::sat32(rnew);
            pcrl_pkg::OP_COMMIT: out_reg <= drv_reg;
            default: ;
        endcase
    end

    assign out_data        = out_reg;
    assign status.div_busy = div_busy;
    assign status.ramp_off = (ramp_reg == 31'd0);
    assign status.out_free = !out_valid || out_ready;

    `PCRL_ASSERT_NOW(a_div_idle_start, cmd.op == pcrl_pkg::OP_DIV, !div_busy,
        "divider started while busy")
    `PCRL_ASSERT_NOW(a_commit_free, do_commit, !out_valid || out_ready,
        "result overwritten before transfer")
    `PCRL_ASSERT_NEXT(a_commit_valid, do_commit, out_valid && out_data == $past(drv_reg),
        "committed result not presented")

endmodule

// ----- rtl/pcrl_ctrl.sv -----
// Sequencer for the PID datapath: one-hot state machine issuing micro-operations.
// Depends on pcrl_pkg.
module pcrl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcrl_pkg::status_t status,
    output pcrl_pkg::cmd_t    cmd
);
    typedef enum logic [22:0] {
        ST_IDLE  = 23'd1 << 0,
        ST_DT    = 23'd1 << 1,
        ST_PMUL  = 23'd1 << 2,
        ST_PSAT  = 23'd1 << 3,
        ST_IMUL  = 23'd1 << 4,
        ST_ILO   = 23'd1 << 5,
        ST_IHI   = 23'd1 << 6,
        ST_ICM   = 23'd1 << 7,
        ST_ICB   = 23'd1 << 8,
        ST_ICF   = 23'd1 << 9,
        ST_IFIN  = 23'd1 << 10,
        ST_DMUL  = 23'd1 << 11,
        ST_DLO   = 23'd1 << 12,
        ST_DHI   = 23'd1 << 13,
        ST_DDIV  = 23'd1 << 14,
        ST_DWAIT = 23'd1 << 15,
        ST_DFIN  = 23'd1 << 16,
        ST_RMUL  = 23'd1 << 17,
        ST_RCM   = 23'd1 << 18,
        ST_RCB   = 23'd1 << 19,
        ST_RCF   = 23'd1 << 20,
        ST_RFIN  = 23'd1 << 21,
        ST_COMMIT = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pcrl_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.op     = pcrl_pkg::OP_LOAD;
                    state_next = ST_DT;
                end
            end
            ST_DT:   begin cmd.op = pcrl_pkg::OP_DT;    state_next = ST_PMUL; end
            ST_PMUL: begin cmd.op = pcrl_pkg::OP_PMUL;  state_next = ST_PSAT; end
            ST_PSAT: begin cmd.op = pcrl_pkg::OP_PSAT;  state_next = ST_IMUL; end
            ST_IMUL: begin cmd.op = pcrl_pkg::OP_IMUL;  state_next = ST_ILO;  end
            ST_ILO:  begin cmd.op = pcrl_pkg::OP_WLO;   state_next = ST_IHI;  end
            ST_IHI:  begin cmd.op = pcrl_pkg::OP_WHI;   state_next = ST_ICM;  end
            ST_ICM:  begin cmd.op = pcrl_pkg::OP_CMUL;  state_next = ST_ICB;  end
            ST_ICB:  begin cmd.op = pcrl_pkg::OP_CBACK; state_next = ST_ICF;  end
            ST_ICF:  begin cmd.op = pcrl_pkg::OP_CFIX;  state_next = ST_IFIN; end
            ST_IFIN: begin cmd.op = pcrl_pkg::OP_IFIN;  state_next = ST_DMUL; end
            ST_DMUL: begin cmd.op = pcrl_pkg::OP_DMUL;  state_next = ST_DLO;  end
            ST_DLO:  begin cmd.op = pcrl_pkg::OP_WLO;   state_next = ST_DHI;  end
            ST_DHI:  begin cmd.op = pcrl_pkg::OP_WHI;   state_next = ST_DDIV; end
            ST_DDIV: begin cmd.op = pcrl_pkg::OP_DIV;   state_next = ST_DWAIT; end
            ST_DWAIT:
            begin
                if (!status.div_busy) state_next = ST_DFIN;
            end
            ST_DFIN:
            begin
                cmd.op     = pcrl_pkg::OP_DFIN;
                state_next = status.ramp_off ? ST_COMMIT : ST_RMUL;
            end
            ST_RMUL: begin cmd.op = pcrl_pkg::OP_RMUL;  state_next = ST_RCM;  end
            ST_RCM:  begin cmd.op = pcrl_pkg::OP_CMUL;  state_next = ST_RCB;  end
            ST_RCB:  begin cmd.op = pcrl_pkg::OP_CBACK; state_next = ST_RCF;  end
            ST_RCF:  begin cmd.op = pcrl_pkg::OP_CFIX;  state_next = ST_RFIN; end
            ST_RFIN: begin cmd.op = pcrl_pkg::OP_RFIN;  state_next = ST_COMMIT; end
            ST_COMMIT:
            begin
                if (status.out_free) begin
                    cmd.op     = pcrl_pkg::OP_COMMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

endmodule

// ----- rtl/pid_controller_ramp_limited.sv -----
// Top level of the ramp-limited PID controller: stream ports, config port.
// Depends on pcrl_pkg, pcrl_ctrl and pcrl_dp.
//
// channel   | signals                        | content
// s_axis    | tvalid tready tdata[63:0]      | error_in, time_now_us
// m_axis    | tvalid tready tdata[31:0]      | drive
// cfg       | cfg_valid cfg_ready idx data   | kp, ki, kd, ramp_rate, output_limit
//
// One item at a time: a new input is accepted only after the previous result is committed, and
// the ramp steps are skipped when rate limiting is off.
// Most of the time goes to the radix-2 divide of the derivative term; an overflowing quotient
// skips the divide. Integral and ramp scaling use reciprocal multiplies.
// Reset clears gains, ramp and loop state and sets the output limit to full scale.
// A result held in the output register stalls only the final commit step.
module pid_controller_ramp_limited (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] error_in, [63:32] time_now_us
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] drive
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    pcrl_pkg::cmd_t    cmd;
    pcrl_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pcrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcrl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for pid_controller_ramp_limited: gains, ramp and limit settings,
// directed and random error/timestamp samples, drive values checked against a local model.
// Depends on pcrl_pkg and the controller RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    pid_controller_ramp_limited uut (.*);

    localparam longint LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 200;

    logic signed [31:0] gain_p, gain_i, gain_d;
    logic [30:0] ramp_per_s, drive_limit;
    logic signed [31:0] prev_err, integ_acc, prev_drive;
    logic [31:0] prev_stamp;
    logic [31:0] drive_q[$];
    logic [31:0] stamp;
    int errors;
    longint cycles = 0;
    bit calm;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint sat_s32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 64'sh7fffffff;
        if (v < -128'sd2147483648) return -64'sh80000000;
        return longint'(v);
    endfunction

    function automatic longint clamp_to(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // signed 128-bit division in SV truncates toward zero
    function automatic logic [31:0] predict_drive(input logic signed [31:0] e,
                                                  input logic [31:0] now);
        logic [31:0] dt;
        logic signed [127:0] w;
        logic signed [127:0] dt_s;
        longint p, di, d, integ, drv, lhs, rhs, stp, lim;
        dt = now - prev_stamp;
        if (dt == 0 || dt > 32'd500000) dt = 32'd1000;
        dt_s = $signed({96'd0, dt});
        lim = longint'(drive_limit);
        w = 128'(signed'(gain_p)) * 128'(signed'(e));
        p = sat_s32(w / 128'sd65536);
        w = 128'(signed'(gain_i)) * (128'(signed'(e)) + 128'(signed'(prev_err))) * dt_s;
        di = sat_s32(w / (128'sd2000000 * 128'sd65536));
        integ = clamp_to(longint'(integ_acc) + di, lim);
        w = 128'(signed'(gain_d)) * (128'(signed'(e)) - 128'(signed'(prev_err)))
            * 128'sd1000000;
        d = sat_s32(w / (dt_s * 128'sd65536));
        drv = clamp_to(p + integ + d, lim);
        if (ramp_per_s != 0)
        begin
            lhs = (drv - longint'(prev_drive)) * 1000000;
            rhs = longint'(ramp_per_s) * longint'(dt);
            stp = rhs / 1000000;
            if (lhs > rhs) drv = longint'(prev_drive) + stp;
            else if (lhs < -rhs) drv = longint'(prev_drive) - stp;
        end
        drv = sat_s32(128'(drv));
        integ_acc = integ[31:0];
        prev_drive = drv[31:0];
        prev_err = e;
        prev_stamp = now;
        return drv[31:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (drive_q.size() == 0)
            begin
                $display("%0t unexpected drive: expected none, actual %h", $time,
                         m_axis_tdata);
                errors++;
            end
            else
            begin
                if (drive_q[0] !== m_axis_tdata)
                begin
                    $display("%0t drive mismatch: expected %h, actual %h", $time,
                             drive_q[0], m_axis_tdata);
                    errors++;
                end
                void'(drive_q.pop_front());
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            pcrl_pkg::CFG_KP: gain_p = val;
            pcrl_pkg::CFG_KI: gain_i = val;
            pcrl_pkg::CFG_KD: gain_d = val;
            pcrl_pkg::CFG_RAMP: ramp_per_s = val[30:0];
            pcrl_pkg::CFG_LIMIT: drive_limit = val[30:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (drive_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_gains(input logic [31:0] p, input logic [31:0] i,
                             input logic [31:0] d, input logic [31:0] r,
                             input logic [31:0] l);
        wait_idle();
        write_reg(pcrl_pkg::CFG_KP, p);
        write_reg(pcrl_pkg::CFG_KI, i);
        write_reg(pcrl_pkg::CFG_KD, d);
        write_reg(pcrl_pkg::CFG_RAMP, r);
        write_reg(pcrl_pkg::CFG_LIMIT, l);
    endtask

    task automatic send_sample(input logic [31:0] e, input logic [31:0] now);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 9)) @(negedge clk);
        s_axis_tdata <= {now, e};
        s_axis_tvalid <= 1'b1;
        drive_q.push_back(predict_drive(e, now));
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_err();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 262144)) - 131072);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 4096)) - 2048) << 8;
        endcase
    endfunction

    function automatic logic [31:0] next_stamp();
        case ($urandom_range(0, 9))
            0: return stamp;
            1: return stamp + $urandom_range(500001, 2000000);
            2: return $urandom;
            default: return stamp + $urandom_range(1, 20000);
        endcase
    endfunction

    task automatic test_directed();
        set_gains(32'h00010000, 32'h00008000, 32'h00000100, 32'd0, 32'h7fffffff);
        send_sample(32'h00010000, 32'd0);
        send_sample(32'h7fffffff, 32'd1000);
        send_sample(32'h80000000, 32'd1000);
        send_sample(32'h80000000, 32'd600000);
        send_sample(32'h00000000, 32'd600001);
        send_sample(32'hffffffff, 32'hfffffff0);
        send_sample(32'h00012345, 32'h00000010);
        set_gains(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00000000);
        send_sample(32'h7fffffff, 32'd500000);
        send_sample(32'h80000000, 32'd1000000);
        set_gains(32'h80000000, 32'h80000000, 32'h80000000, 32'd0, 32'h7fffffff);
        send_sample(32'h7fffffff, 32'd1000001);
        send_sample(32'h80000000, 32'd1000002);
        send_sample(32'h00000001, 32'd1500002);
        set_gains(32'h00020000, 32'h00010000, 32'h00000000, 32'h00010000, 32'h00100000);
        send_sample(32'h00100000, 32'd2000000);
        send_sample(32'hfff00000, 32'd2001000);
        send_sample(32'h00100000, 32'd2400000);
        set_gains(32'h00020000, 32'h00010000, 32'h00000000, 32'h00010000, 32'h00000100);
        send_sample(32'h00000000, 32'd2401000);
        send_sample(32'h00000000, 32'd2402000);
        stamp = 32'd2402000;
    endtask

    task automatic test_random_phase(input int count);
        logic [31:0] lims[4];
        lims = '{32'h7fffffff, 32'h00000000, 32'h00010000, $urandom};
        set_gains($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40000),
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40000),
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h400),
                  $urandom_range(0, 2) == 0 ? 32'd0 : $urandom,
                  lims[$urandom_range(0, 3)]);
        repeat (count)
        begin
            stamp = next_stamp();
            send_sample(rand_err(), stamp);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        calm = 1'b0;
        stamp = '0;
        gain_p = '0; gain_i = '0; gain_d = '0;
        ramp_per_s = '0; drive_limit = 31'h7fffffff;
        prev_err = '0; integ_acc = '0; prev_drive = '0; prev_stamp = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        repeat (14) test_random_phase(120);
        wait_idle();
        write_reg(3'd7, $urandom);
        calm = 1'b1;
        test_random_phase(300);
        wait_idle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcrl_pkg.sv
rtl/pcrl_div.sv
rtl/pcrl_dp.sv
rtl/pcrl_ctrl.sv
rtl/pid_controller_ramp_limited.sv
verif/testbench.sv
